// ===== src/mwsm_pkg.sv =====
// Package: shared types, constants and register indexes of the wheel speed mixer.
package mwsm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_PLUS_TRACK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_RATIO       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VX        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VY        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VW        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_WHEEL     = 3'd7;

  localparam logic signed [11:0] DEG2RAD_Q16 = 12'sd1144;

  // raw wheel speed: |lin - rot| < 2^26, times ratio < 2^24, over 2^24 -> fits 28 bits signed
  localparam int unsigned RAW_W = 28;
  localparam int unsigned MAG_W = RAW_W - 1;

  // clamped command as handed from front to back
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vw;
  } cmd_t;

  typedef struct packed {
    logic [12:0]        base_plus_track;
    logic signed [11:0] center_x_offset;
    logic signed [11:0] center_y_offset;
    logic [23:0]        rpm_ratio;
    logic [14:0]        limit_wheel;
  } geom_t;

  // all four wheels' raw speed record, with peak and limit, headed for the scaler
  typedef struct packed {
    logic signed [RAW_W-1:0] raw0;
    logic signed [RAW_W-1:0] raw1;
    logic signed [RAW_W-1:0] raw2;
    logic signed [RAW_W-1:0] raw3;
    logic [MAG_W-1:0]        mag;
    logic [14:0]             lim;
  } mix_t;

endpackage

// ===== src/mwsm_front.sv =====
// Front end: clamps each accepted command to its limits and queues it.
module mwsm_front
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] speed_x,
  input  logic signed [15:0] speed_y,
  input  logic signed [15:0] speed_w,
  input  logic [14:0]        limit_vx,
  input  logic [14:0]        limit_vy,
  input  logic [14:0]        limit_vw,
  output logic               cmd_valid,
  output cmd_t               cmd
);

  function automatic logic signed [15:0] clampsym(logic signed [15:0] v, logic [14:0] lim);
    logic signed [16:0] l;
    logic signed [16:0] w;
    begin
      l = {2'b00, lim};
      w = {v[15], v};
      if (w > l) clampsym = l[15:0];
      else if (w < -l) clampsym = 16'(-l);
      else clampsym = v;
    end
  endfunction

  // one stage queue register; back end never stalls, so it drains each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start;
    end
    cmd.vx <= clampsym(speed_x, limit_vx);
    cmd.vy <= clampsym(speed_y, limit_vy);
    cmd.vw <= clampsym(speed_w, limit_vw);
  end

endmodule

// ===== src/mwsm_mix.sv =====
// Wheel mixer: lever arms, rotation term, rpm ratio and peak magnitude.
module mwsm_mix
  import mwsm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  input  cmd_t  cmd,
  input  geom_t geom,
  output logic  mix_valid,
  output mix_t  mix
);

  logic signed [15:0] arm [4];
  logic signed [16:0] lin [4];
  logic [2:0]         v;

  // stage 1 registers
  logic signed [31:0] vwarm [4];
  logic signed [16:0] lin1  [4];
  // stage 2
  logic signed [31:0] rot2  [4];
  logic signed [16:0] lin2  [4];
  // stage 3
  logic signed [RAW_W-1:0] raw3 [4];

  logic signed [43:0] rotp [4];
  logic signed [50:0] rawp [4];
  logic signed [33:0] diff [4];
  logic [MAG_W-1:0]   a [4];
  logic [MAG_W-1:0]   m01, m23;

  always_comb begin
    logic signed [15:0] s, x2, y2;
    s  = {3'b000, geom.base_plus_track};
    x2 = 16'({{3{geom.center_x_offset[11]}}, geom.center_x_offset, 1'b0});
    y2 = 16'({{3{geom.center_y_offset[11]}}, geom.center_y_offset, 1'b0});
    arm[0] = s - x2 + y2;
    arm[1] = s - x2 - y2;
    arm[2] = s + x2 - y2;
    arm[3] = s + x2 + y2;
    lin[0] = -17'(cmd.vx) - 17'(cmd.vy);
    lin[1] =  17'(cmd.vx) - 17'(cmd.vy);
    lin[2] =  17'(cmd.vx) + 17'(cmd.vy);
    lin[3] = -17'(cmd.vx) + 17'(cmd.vy);
    for (int i = 0; i < 4; i++) begin
      rotp[i] = 44'(vwarm[i]) * 44'(DEG2RAD_Q16);
      diff[i] = 34'(lin2[i]) - 34'(rot2[i]);
      rawp[i] = 51'(diff[i]) * $signed({27'd0, geom.rpm_ratio});
      a[i]    = raw3[i][RAW_W-1] ? MAG_W'(-raw3[i]) : MAG_W'(raw3[i]);
    end
    m01 = (a[0] > a[1]) ? a[0] : a[1];
    m23 = (a[2] > a[3]) ? a[2] : a[3];
  end

  // truncating division by a power of two toward zero
  function automatic logic signed [31:0] shr17(logic signed [43:0] p);
    logic signed [43:0] q;
    begin
      q = p[43] ? (p + 44'sd131071) : p;
      shr17 = 32'(q >>> 17);
    end
  endfunction

  function automatic logic signed [RAW_W-1:0] shr24(logic signed [50:0] p);
    logic signed [50:0] q;
    begin
      q = p[50] ? (p + 51'sd16777215) : p;
      shr24 = RAW_W'(q >>> 24);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      mix_valid <= 1'b0;
    end else begin
      v <= {v[1:0], cmd_valid};
      mix_valid <= v[2];
    end
    for (int i = 0; i < 4; i++) begin
      vwarm[i] <= 32'(cmd.vw) * 32'(arm[i]);
      lin1[i]  <= lin[i];
      rot2[i]  <= shr17(rotp[i]);
      lin2[i]  <= lin1[i];
      raw3[i]  <= shr24(rawp[i]);
    end
    mix.raw0 <= raw3[0];
    mix.raw1 <= raw3[1];
    mix.raw2 <= raw3[2];
    mix.raw3 <= raw3[3];
    mix.mag  <= (m01 > m23) ? m01 : m23;
    mix.lim  <= geom.limit_wheel;
  end

endmodule

// ===== src/mwsm_scale.sv =====
// Wheel limit scaler: pipelined restoring divide of raw*limit by peak.
module mwsm_scale
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               mix_valid,
  input  mix_t               mix,
  output logic               done,
  output logic signed [15:0] rpm_front_right,
  output logic signed [15:0] rpm_front_left,
  output logic signed [15:0] rpm_back_left,
  output logic signed [15:0] rpm_back_right,
  output logic               was_scaled
);

  // quotient |raw|*lim/m <= lim < 2^15: 15 quotient bits, one per stage
  localparam int unsigned QW = 15;
  localparam int unsigned NW = MAG_W + 15;

  typedef struct packed {
    logic [3:0]             neg;
    logic [3:0][MAG_W:0]    rem;
    logic [3:0][NW-1:0]     num;
    logic [3:0][QW-1:0]     q;
    logic [MAG_W-1:0]       den;
    logic                   scale;
    logic [3:0][15:0]       pass;
  } div_t;

  div_t st [QW+1];
  logic vld [QW+1];
  div_t s0;

  logic [MAG_W-1:0] ab [4];
  logic signed [RAW_W-1:0] r [4];

  // products |raw|*lim: 27x15 bits, registered into stage 0
  // numerator bits above QW seed the remainder: they sit below the divisor
  // because the quotient fits in QW bits
  always_comb begin
    r[0] = mix.raw0; r[1] = mix.raw1; r[2] = mix.raw2; r[3] = mix.raw3;
    s0 = '0;
    s0.den   = mix.mag;
    s0.scale = mix.mag > MAG_W'(mix.lim);
    for (int i = 0; i < 4; i++) begin
      ab[i]      = r[i][RAW_W-1] ? MAG_W'(-r[i]) : MAG_W'(r[i]);
      s0.neg[i]  = r[i][RAW_W-1];
      s0.num[i]  = NW'(ab[i]) * NW'(mix.lim);
      s0.rem[i]  = {1'b0, s0.num[i][NW-1:QW]};
      s0.pass[i] = r[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= mix_valid;
    st[0] <= s0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    div_t nx;
    always_comb begin
      logic [MAG_W+1:0] t;
      nx = st[k];
      for (int i = 0; i < 4; i++) begin
        t = {st[k].rem[i], st[k].num[i][QW-1-k]};
        if (t >= {2'b00, st[k].den}) begin
          nx.rem[i] = (MAG_W+1)'(t - {2'b00, st[k].den});
          nx.q[i]   = {st[k].q[i][QW-2:0], 1'b1};
        end else begin
          nx.rem[i] = t[MAG_W:0];
          nx.q[i]   = {st[k].q[i][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= vld[k];
      st[k+1] <= nx;
    end
  end

  // signed result: scaled quotient, or the raw speed when the peak does not exceed the limit
  function automatic logic [15:0] pick(div_t d, int i);
    logic [15:0] qs;
    begin
      qs = d.neg[i] ? 16'(-{1'b0, d.q[i]}) : {1'b0, d.q[i]};
      pick = d.scale ? qs : d.pass[i];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QW];
    end
    rpm_front_right <= pick(st[QW], 0);
    rpm_front_left  <= pick(st[QW], 1);
    rpm_back_left   <= pick(st[QW], 2);
    rpm_back_right  <= pick(st[QW], 3);
    was_scaled      <= st[QW].scale;
  end

endmodule

// ===== src/mecanum_wheel_speed_mixer.sv =====
// Top level of the four-wheel mecanum speed mixer.
// Takes one velocity request per clock (start, no busy time: busy stays low)
// and gives four wheel rpm values plus a scaled flag, marked by a one-cycle
// done strobe. Each request is registered through the mixer's three multiply
// stages and the scaler's 15-stage restoring divider (one quotient bit per
// stage). The receiver cannot stall; results must be taken when done is high.
// Registers may only be written while no request is in flight.
module mecanum_wheel_speed_mixer
  import mwsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    speed_x,
  input  logic signed [15:0]    speed_y,
  input  logic signed [15:0]    speed_w,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic signed [15:0]    rpm_front_right,
  output logic signed [15:0]    rpm_front_left,
  output logic signed [15:0]    rpm_back_left,
  output logic signed [15:0]    rpm_back_right,
  output logic                  was_scaled
);

  geom_t       geom;
  logic [14:0] limit_vx, limit_vy, limit_vw;
  logic        cmd_valid, mix_valid;
  cmd_t        cmd;
  mix_t        mix;

  // fully pipelined: never refuses a request
  assign busy = 1'b0;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.base_plus_track <= '0;
      geom.center_x_offset <= '0;
      geom.center_y_offset <= '0;
      geom.rpm_ratio       <= '0;
      geom.limit_wheel     <= 15'h7FFF;
      limit_vx             <= 15'h7FFF;
      limit_vy             <= 15'h7FFF;
      limit_vw             <= 15'h7FFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_PLUS_TRACK: geom.base_plus_track <= cfg_data[12:0];
        REG_CENTER_X_OFFSET: geom.center_x_offset <= cfg_data[11:0];
        REG_CENTER_Y_OFFSET: geom.center_y_offset <= cfg_data[11:0];
        REG_RPM_RATIO:       geom.rpm_ratio       <= cfg_data[23:0];
        REG_LIMIT_VX:        limit_vx             <= cfg_data[14:0];
        REG_LIMIT_VY:        limit_vy             <= cfg_data[14:0];
        REG_LIMIT_VW:        limit_vw             <= cfg_data[14:0];
        REG_LIMIT_WHEEL:     geom.limit_wheel     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // front: clamp and queue
  mwsm_front u_front (
    .clk, .rst, .start, .speed_x, .speed_y, .speed_w,
    .limit_vx, .limit_vy, .limit_vw, .cmd_valid, .cmd
  );

  // back: mix, then scale against the wheel limit
  mwsm_mix u_mix (
    .clk, .rst, .cmd_valid, .cmd, .geom, .mix_valid, .mix
  );

  mwsm_scale u_scale (
    .clk, .rst, .mix_valid, .mix, .done,
    .rpm_front_right, .rpm_front_left, .rpm_back_left, .rpm_back_right, .was_scaled
  );

endmodule

// ===== src/mwsm_checker.sv =====
// Port-level checker for the wheel speed mixer, bound to the top level.
module mwsm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] rpm_front_right,
  input logic               was_scaled
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##22 done)
    else $error("result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 22))
    else $error("unrequested result");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rpm_front_right != 16'sh8000)
    else $error("wheel speed out of range");

  a_flag_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(was_scaled))
    else $error("scaled flag unknown");

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_chk (
  .clk, .rst, .start, .busy, .done, .rpm_front_right, .was_scaled
);
